// ===== rtl/rcsr_pkg.sv =====
// rcsr_pkg: shared types, CSR numbers, masks and operation codes for the
// RV32 CSR and trap unit. No dependencies.
`timescale 1ns / 1ps
package rcsr_pkg;

  localparam int XLEN = 32;

  typedef enum logic [2:0] {
    FN_READ  = 3'd0,
    FN_WRITE = 3'd1,
    FN_TRAP  = 3'd2,
    FN_MRET  = 3'd3,
    FN_SRET  = 3'd4,
    FN_IRQ   = 3'd5
  } func_t;

  typedef enum logic [0:0] {
    CFG_HART_ID  = 1'd0,
    CFG_ISA_BITS = 1'd1
  } cfg_index_t;

  localparam logic [11:0] ADR_SSTATUS  = 12'h100;
  localparam logic [11:0] ADR_SIE      = 12'h104;
  localparam logic [11:0] ADR_STVEC    = 12'h105;
  localparam logic [11:0] ADR_SCOUNTEN = 12'h106;
  localparam logic [11:0] ADR_SSCRATCH = 12'h140;
  localparam logic [11:0] ADR_SEPC     = 12'h141;
  localparam logic [11:0] ADR_SCAUSE   = 12'h142;
  localparam logic [11:0] ADR_STVAL    = 12'h143;
  localparam logic [11:0] ADR_SIP      = 12'h144;
  localparam logic [11:0] ADR_SATP     = 12'h180;
  localparam logic [11:0] ADR_MSTATUS  = 12'h300;
  localparam logic [11:0] ADR_MISA     = 12'h301;
  localparam logic [11:0] ADR_MEDELEG  = 12'h302;
  localparam logic [11:0] ADR_MIDELEG  = 12'h303;
  localparam logic [11:0] ADR_MIE      = 12'h304;
  localparam logic [11:0] ADR_MTVEC    = 12'h305;
  localparam logic [11:0] ADR_MCOUNTEN = 12'h306;
  localparam logic [11:0] ADR_MSCRATCH = 12'h340;
  localparam logic [11:0] ADR_MEPC     = 12'h341;
  localparam logic [11:0] ADR_MCAUSE   = 12'h342;
  localparam logic [11:0] ADR_MTVAL    = 12'h343;
  localparam logic [11:0] ADR_MIP      = 12'h344;
  localparam logic [11:0] ADR_MCYCLE   = 12'hB00;
  localparam logic [11:0] ADR_MINSTRET = 12'hB02;
  localparam logic [11:0] ADR_CYCLE    = 12'hC00;
  localparam logic [11:0] ADR_TIME     = 12'hC01;
  localparam logic [11:0] ADR_INSTRET  = 12'hC02;
  localparam logic [11:0] ADR_MCYCLEH  = 12'hB80;
  localparam logic [11:0] ADR_MINSTRH  = 12'hB82;
  localparam logic [11:0] ADR_CYCLEH   = 12'hC80;
  localparam logic [11:0] ADR_TIMEH    = 12'hC81;
  localparam logic [11:0] ADR_INSTRETH = 12'hC82;
  localparam logic [11:0] ADR_MHARTID  = 12'hF14;

  localparam logic [31:0] ST_FS_FORCE = 32'h0000_6000;
  localparam logic [31:0] ST_SD       = 32'h8000_0000;
  localparam logic [31:0] SST_MASK    = 32'h000d_e133;
  localparam logic [31:0] MST_WMASK   = 32'h000E_19BB;
  localparam logic [31:0] ISA_XLEN32  = 32'h4000_0000;
  localparam logic [31:0] ST_MPRV     = 32'h0002_0000;
  localparam logic [31:0] ST_SUM      = 32'h0004_0000;
  localparam logic [31:0] ST_MXR      = 32'h0008_0000;
  localparam logic [31:0] ST_MPP      = 32'h0000_1800;
  localparam logic [31:0] EXT_IRQ     = 32'h0000_0A00;
  localparam logic [31:0] MIDELEG_W   = 32'h0000_0222;
  localparam logic [31:0] MIE_W       = 32'h0000_02AA;
  localparam logic [31:0] MIP_W       = 32'h0000_0022;
  localparam logic [31:0] MEDELEG_W   = 32'h0000_FFFF;

  localparam logic [1:0] PRIV_U = 2'd0;
  localparam logic [1:0] PRIV_S = 2'd1;
  localparam logic [1:0] PRIV_M = 2'd3;

  typedef struct packed {
    logic [2:0]  func;
    logic [11:0] csr_address;
    logic [31:0] write_data;
    logic [31:0] trap_cause;
    logic [31:0] trap_value;
    logic [31:0] current_pc;
    logic [5:0]  irq_number;
    logic        irq_level;
    logic [31:0] served_mask;
    logic [63:0] time_now;
  } op_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        redirect;
    logic [31:0] next_pc;
    logic [1:0]  next_priv;
    logic        flush_tlb;
  } res_t;

  // status view under a mask, FS forced to dirty, SD derived
  function automatic logic [31:0] status_view(input logic [31:0] st, input logic [31:0] mask);
    logic [31:0] v;
    v = (st | ST_FS_FORCE) & mask;
    if (v[14:13] == 2'b11 || v[16:15] == 2'b11) v = v | ST_SD;
    return v;
  endfunction

endpackage

// ===== rtl/rcsr_if.sv =====
// rcsr_if: valid/ready channel carrying one word of type T.
// The payload type is given by the parameter T; no package dependency.
`timescale 1ns / 1ps
interface rcsr_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/rcsr_core.sv =====
// rcsr_core: architectural CSR state and the single-pass update for one
// operation (read, write, trap, mret, sret, irq line). Depends on rcsr_pkg.
`timescale 1ns / 1ps
module rcsr_core
  import rcsr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        step,
  input  op_t         op,
  input  logic [31:0] hart_id,
  input  logic [29:0] isa_bits,
  output res_t        res
);

  logic [31:0] status_word, int_enable, int_pending, int_delegate, exc_delegate;
  logic [31:0] m_trap_vector, s_trap_vector, m_epc, s_epc, m_cause, s_cause;
  logic [31:0] m_tval, s_tval, m_scratch, s_scratch, translation_root, source_pending;
  logic [2:0]  m_counter_enable, s_counter_enable;
  logic [1:0]  privilege;

  logic [31:0] status_word_next, int_enable_next, int_pending_next, int_delegate_next;
  logic [31:0] exc_delegate_next, m_trap_vector_next, s_trap_vector_next;
  logic [31:0] m_epc_next, s_epc_next, m_cause_next, s_cause_next, m_tval_next;
  logic [31:0] s_tval_next, m_scratch_next, s_scratch_next, translation_root_next;
  logic [31:0] source_pending_next;
  logic [2:0]  m_counter_enable_next, s_counter_enable_next;
  logic [1:0]  privilege_next;

  logic [31:0] rd, npc, sw_in, diff, sel, src, stat_tmp;
  logic        redir, flush, deleg, prev_ie, pie;
  logic [1:0]  rp;

  // compute next state and result for the current operation
  always_comb begin
    status_word_next = status_word;           privilege_next = privilege;
    int_enable_next = int_enable;             int_pending_next = int_pending;
    int_delegate_next = int_delegate;         exc_delegate_next = exc_delegate;
    m_trap_vector_next = m_trap_vector;       s_trap_vector_next = s_trap_vector;
    m_epc_next = m_epc;                       s_epc_next = s_epc;
    m_cause_next = m_cause;                   s_cause_next = s_cause;
    m_tval_next = m_tval;                     s_tval_next = s_tval;
    m_scratch_next = m_scratch;               s_scratch_next = s_scratch;
    translation_root_next = translation_root; source_pending_next = source_pending;
    m_counter_enable_next = m_counter_enable; s_counter_enable_next = s_counter_enable;
    rd = '0; npc = '0; redir = 1'b0; flush = 1'b0; deleg = 1'b0;
    sw_in = '0; diff = '0; sel = '0; src = source_pending; stat_tmp = status_word;
    prev_ie = status_word[privilege]; pie = 1'b0; rp = '0;

    case (func_t'(op.func))
      FN_READ: begin
        case (op.csr_address)
          ADR_SSTATUS:  rd = status_view(status_word, SST_MASK);
          ADR_SIE:      rd = int_enable & int_delegate;
          ADR_STVEC:    rd = s_trap_vector;
          ADR_SCOUNTEN: rd = {29'd0, s_counter_enable};
          ADR_SSCRATCH: rd = s_scratch;
          ADR_SEPC:     rd = s_epc;
          ADR_SCAUSE:   rd = s_cause;
          ADR_STVAL:    rd = s_tval;
          ADR_SIP:      rd = int_pending & int_delegate;
          ADR_SATP:     rd = translation_root;
          ADR_MSTATUS:  rd = status_view(status_word, 32'hFFFF_FFFF);
          ADR_MISA:     rd = {2'b00, isa_bits} | ISA_XLEN32;
          ADR_MEDELEG:  rd = exc_delegate;
          ADR_MIDELEG:  rd = int_delegate;
          ADR_MIE:      rd = int_enable;
          ADR_MTVEC:    rd = m_trap_vector;
          ADR_MCOUNTEN: rd = {29'd0, m_counter_enable};
          ADR_MSCRATCH: rd = m_scratch;
          ADR_MEPC:     rd = m_epc;
          ADR_MCAUSE:   rd = m_cause;
          ADR_MTVAL:    rd = m_tval;
          ADR_MIP:      rd = int_pending;
          ADR_MCYCLE, ADR_MINSTRET, ADR_CYCLE, ADR_TIME, ADR_INSTRET:
            rd = op.time_now[31:0];
          ADR_MCYCLEH, ADR_MINSTRH, ADR_CYCLEH, ADR_TIMEH, ADR_INSTRETH:
            rd = op.time_now[63:32];
          ADR_MHARTID:  rd = hart_id;
          default:      rd = '0;
        endcase
      end
      FN_WRITE: begin
        case (op.csr_address)
          ADR_SSTATUS, ADR_MSTATUS: begin
            sw_in = (op.csr_address == ADR_SSTATUS)
                  ? ((status_word & ~SST_MASK) | (op.write_data & SST_MASK))
                  : op.write_data;
            diff = status_word ^ sw_in;
            flush = ((diff & (ST_MPRV | ST_SUM | ST_MXR)) != '0) ||
                    (status_word[17] && ((diff & ST_MPP) != '0));
            status_word_next = (status_word & ~MST_WMASK) | (sw_in & MST_WMASK);
          end
          ADR_SIE: int_enable_next = (int_enable & ~int_delegate) |
                                     (op.write_data & int_delegate);
          ADR_STVEC:    s_trap_vector_next = {op.write_data[31:2], 2'b00};
          ADR_SCOUNTEN: s_counter_enable_next = op.write_data[2:0] & 3'b101;
          ADR_SSCRATCH: s_scratch_next = op.write_data;
          ADR_SEPC:     s_epc_next = {op.write_data[31:1], 1'b0};
          ADR_SCAUSE:   s_cause_next = op.write_data;
          ADR_STVAL:    s_tval_next = op.write_data;
          ADR_SIP: int_pending_next = (int_pending & ~int_delegate) |
                                      (op.write_data & int_delegate);
          ADR_SATP:     translation_root_next = op.write_data;
          ADR_MEDELEG:  exc_delegate_next = (exc_delegate & ~MEDELEG_W) |
                                            (op.write_data & MEDELEG_W);
          ADR_MIDELEG:  int_delegate_next = (int_delegate & ~MIDELEG_W) |
                                            (op.write_data & MIDELEG_W);
          ADR_MIE:      int_enable_next = (int_enable & ~MIE_W) | (op.write_data & MIE_W);
          ADR_MTVEC:    m_trap_vector_next = {op.write_data[31:2], 2'b00};
          ADR_MCOUNTEN: m_counter_enable_next = op.write_data[2:0] & 3'b101;
          ADR_MSCRATCH: m_scratch_next = op.write_data;
          ADR_MEPC:     m_epc_next = {op.write_data[31:1], 1'b0};
          ADR_MCAUSE:   m_cause_next = op.write_data;
          ADR_MTVAL:    m_tval_next = op.write_data;
          ADR_MIP:      int_pending_next = (int_pending & ~MIP_W) | (op.write_data & MIP_W);
          default: ;
        endcase
      end
      FN_TRAP: begin
        sel = op.trap_cause[31] ? int_delegate : exc_delegate;
        deleg = (privilege <= PRIV_S) && sel[op.trap_cause[4:0]];
        redir = 1'b1; flush = 1'b1;
        if (deleg) begin
          s_cause_next = op.trap_cause; s_epc_next = op.current_pc;
          s_tval_next = op.trap_value;
          stat_tmp[5] = prev_ie; stat_tmp[8] = privilege[0]; stat_tmp[1] = 1'b0;
          privilege_next = PRIV_S; npc = s_trap_vector;
        end else begin
          m_cause_next = op.trap_cause; m_epc_next = op.current_pc;
          m_tval_next = op.trap_value;
          stat_tmp[7] = prev_ie; stat_tmp[12:11] = privilege; stat_tmp[3] = 1'b0;
          privilege_next = PRIV_M; npc = m_trap_vector;
        end
        status_word_next = stat_tmp;
      end
      FN_MRET: begin
        rp = status_word[12:11]; pie = status_word[7];
        stat_tmp[rp] = pie; stat_tmp[7] = 1'b1; stat_tmp[12:11] = 2'b00;
        status_word_next = stat_tmp; privilege_next = rp;
        npc = m_epc; redir = 1'b1; flush = 1'b1;
      end
      FN_SRET: begin
        rp = {1'b0, status_word[8]}; pie = status_word[5];
        stat_tmp[rp] = pie; stat_tmp[5] = 1'b1; stat_tmp[8] = 1'b0;
        status_word_next = stat_tmp; privilege_next = rp;
        npc = s_epc; redir = 1'b1; flush = 1'b1;
      end
      FN_IRQ: begin
        if (op.irq_number >= 6'd1 && op.irq_number <= 6'd32) begin
          src[5'(op.irq_number - 6'd1)] = op.irq_level;
        end
        source_pending_next = src;
        int_pending_next = ((src & ~op.served_mask) != '0)
                         ? (int_pending | EXT_IRQ) : (int_pending & ~EXT_IRQ);
      end
      default: ;
    endcase

    res.read_data = rd;
    res.redirect  = redir;
    res.next_pc   = npc;
    res.next_priv = privilege_next;
    res.flush_tlb = flush;
  end

  // commit state on each accepted operation
  always_ff @(posedge clk) begin
    if (rst) begin
      status_word <= '0; privilege <= PRIV_M;
      int_enable <= '0; int_pending <= '0; int_delegate <= '0; exc_delegate <= '0;
      m_trap_vector <= '0; s_trap_vector <= '0; m_epc <= '0; s_epc <= '0;
      m_cause <= '0; s_cause <= '0; m_tval <= '0; s_tval <= '0;
      m_scratch <= '0; s_scratch <= '0; translation_root <= '0;
      m_counter_enable <= '0; s_counter_enable <= '0; source_pending <= '0;
    end else if (step) begin
      status_word <= status_word_next; privilege <= privilege_next;
      int_enable <= int_enable_next; int_pending <= int_pending_next;
      int_delegate <= int_delegate_next; exc_delegate <= exc_delegate_next;
      m_trap_vector <= m_trap_vector_next; s_trap_vector <= s_trap_vector_next;
      m_epc <= m_epc_next; s_epc <= s_epc_next;
      m_cause <= m_cause_next; s_cause <= s_cause_next;
      m_tval <= m_tval_next; s_tval <= s_tval_next;
      m_scratch <= m_scratch_next; s_scratch <= s_scratch_next;
      translation_root <= translation_root_next;
      m_counter_enable <= m_counter_enable_next;
      s_counter_enable <= s_counter_enable_next;
      source_pending <= source_pending_next;
    end
  end

`ifndef SYNTHESIS
  // privilege level 2 is only reachable through mret
  a_priv_trap: assert property (@(posedge clk) disable iff (rst)
    step && op.func == FN_TRAP |=> privilege == PRIV_S || privilege == PRIV_M)
    else $error("trap left an illegal privilege");
  // no state change without an accepted operation
  a_hold: assert property (@(posedge clk) disable iff (rst)
    !step |=> $stable(status_word) && $stable(privilege) && $stable(source_pending))
    else $error("state moved while idle");
  // delegated traps only come from user or supervisor mode
  a_deleg: assert property (@(posedge clk) disable iff (rst)
    step && op.func == FN_TRAP && privilege_next == PRIV_S |-> privilege <= PRIV_S)
    else $error("delegated trap from machine mode");
`endif

endmodule

// ===== rtl/rv32_csr_trap_unit.sv =====
// rv32_csr_trap_unit: top level; input register, CSR core and output register.
// Depends on rcsr_pkg, rcsr_if and rcsr_core.
`timescale 1ns / 1ps
// One operation per cycle while the output side takes results: each accepted
// word is registered, evaluated by the CSR core and its result placed in a
// one-word output register. Input ready falls only when both the input
// register and the output register hold words the sink has not taken.
// Configuration (hart id, ISA bits) is written through a plain write port.
module rv32_csr_trap_unit
  import rcsr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [31:0] cfg_data,
  rcsr_if.sink        in_ch,
  rcsr_if.source      out_ch
);

  logic [31:0] hart_id;
  logic [29:0] isa_bits;
  op_t         op;
  logic        op_valid;
  res_t        res, res_q;
  logic        res_valid, step;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      hart_id <= '0; isa_bits <= '0;
    end else if (cfg_we) begin
      case (cfg_index_t'(cfg_index))
        CFG_HART_ID:  hart_id <= cfg_data;
        CFG_ISA_BITS: isa_bits <= cfg_data[29:0];
        default: ;
      endcase
    end
  end

  // advance when the output register is free or being taken
  assign step = op_valid && (!res_valid || out_ch.ready);
  assign in_ch.ready = !op_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      op_valid <= 1'b0;
    end else if (in_ch.ready) begin
      op_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) op <= in_ch.data;
  end

  rcsr_core u_core (
    .clk(clk), .rst(rst), .step(step), .op(op),
    .hart_id(hart_id), .isa_bits(isa_bits), .res(res)
  );

  // hold the result until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (step) begin
      res_valid <= 1'b1;
    end else if (out_ch.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) res_q <= res;
  end

  assign out_ch.valid = res_valid;
  assign out_ch.data  = res_q;

`ifndef SYNTHESIS
  // a stalled result is never overwritten
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    res_valid && !out_ch.ready |-> !step)
    else $error("result overwritten");
  // an operation stepped through the core leads to a valid result in the next cycle
  a_flow: assert property (@(posedge clk) disable iff (rst)
    step |=> res_valid)
    else $error("result lost");
  // input stays open while the pipe is empty
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !op_valid |-> in_ch.ready)
    else $error("ready dropped while empty");
`endif

endmodule
